>>> rtl/cc20_pkg.sv
// Shared types, constants and state encodings for the ChaCha20 stream cipher.
package cc20_pkg;

   localparam int DR_DEFAULT = 10;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_01   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_23   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_45   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_67   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_01 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_2  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_CTR = 3'd6;

   localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                         32'h3320646e, 32'h61707865};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } cc20_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cc20_rsp_type;

   typedef struct packed {
      logic [7:0][31:0] key;
      logic [2:0][31:0] nonce;
   } cc20_block_cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] count;
   } cc20_cmd_type;

   typedef struct packed {
      logic done;
   } cc20_status_type;

   typedef enum logic [1:0] {
      TS_IDLE,
      TS_GEN,
      TS_OUT
   } cc20_top_state_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_ROUND,
      CS_DIAG,
      CS_UNDIAG,
      CS_ADD
   } cc20_core_state_type;

endpackage

>>> rtl/cc20_core.sv
// Block function: one shared add-xor-rotate unit sequenced over the 16-word state.
module cc20_core #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DR_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cc20_pkg::cc20_cmd_type       cmd_in,
   input  cc20_pkg::cc20_block_cfg_type cfg_in,
   input  logic [5:0]                   pos_in,
   output cc20_pkg::cc20_status_type    status_out,
   output logic [7:0]                   ks_byte_out
);
   import cc20_pkg::*;

   localparam int DR_W = $clog2(DOUBLE_ROUNDS + 1);
   localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

   cc20_core_state_type state_ff, state_in;
   logic [31:0]     work_ff [16];
   logic [31:0]     work_in [16];
   logic [31:0]     ctr_ff, ctr_in, ctr_sel;
   logic [1:0]      step_ff, step_in, col_ff, col_in;
   logic            diag_ff, diag_in;
   logic [DR_W-1:0] dr_ff, dr_in;
   logic [3:0]      word_ff, word_in;
   logic [31:0]     init_w [16];
   logic [31:0]     op_x, op_y, op_z, sum, mixed, rotated;
   logic [31:0]     stepped [16];
   logic [31:0]     row_rot [16];
   logic [31:0]     diag_w [16];
   logic [31:0]     undiag_w [16];
   logic            qr_end, half_end;

   assign ctr_sel = (state_ff == CS_IDLE) ? cmd_in.count : ctr_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init_w[i] = SIGMA[i];
      end
      for (int i = 0; i < 8; i++) begin
         init_w[4 + i] = cfg_in.key[i];
      end
      init_w[12] = ctr_sel;
      for (int i = 0; i < 3; i++) begin
         init_w[13 + i] = cfg_in.nonce[i];
      end
   end

   // The shared unit: x + y, then (z ^ sum) rotated left.
   always_comb begin
      op_x = work_ff[0];
      op_y = work_ff[4];
      op_z = work_ff[12];
      if (state_ff == CS_ADD) begin
         op_y = init_w[word_ff];
      end else if (step_ff[0]) begin
         op_x = work_ff[8];
         op_y = work_ff[12];
         op_z = work_ff[4];
      end
      sum   = op_x + op_y;
      mixed = op_z ^ sum;
      case (step_ff)
         2'd0:    rotated = {mixed[15:0], mixed[31:16]};
         2'd1:    rotated = {mixed[19:0], mixed[31:20]};
         2'd2:    rotated = {mixed[23:0], mixed[31:24]};
         default: rotated = {mixed[24:0], mixed[31:25]};
      endcase
   end

   // The quarter round always works on column 0; rows are rotated to bring
   // the next column or diagonal into place.
   always_comb begin
      stepped = work_ff;
      if (step_ff[0]) begin
         stepped[8] = sum;
         stepped[4] = rotated;
      end else begin
         stepped[0]  = sum;
         stepped[12] = rotated;
      end
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 4; j++) begin
            row_rot[4*r + j]  = stepped[4*r + ((j + 1) % 4)];
            diag_w[4*r + j]   = work_ff[4*r + ((j + r) % 4)];
            undiag_w[4*r + j] = work_ff[4*r + ((j + 4 - r) % 4)];
         end
      end
   end

   assign qr_end   = (step_ff == 2'd3);
   assign half_end = qr_end && (col_ff == 2'd3);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (cmd_in.start) begin
               state_in = CS_ROUND;
            end
         end
         CS_ROUND: begin
            if (half_end) begin
               state_in = diag_ff ? CS_UNDIAG : CS_DIAG;
            end
         end
         CS_DIAG: begin
            state_in = CS_ROUND;
         end
         CS_UNDIAG: begin
            state_in = (dr_ff == DR_LAST) ? CS_ADD : CS_ROUND;
         end
         CS_ADD: begin
            if (word_ff == 4'd15) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      status_out.done = (state_ff == CS_ADD) && (word_ff == 4'd15);
      ks_byte_out     = work_ff[pos_in[5:2]][{pos_in[1:0], 3'b000} +: 8];
   end

   always_comb begin
      work_in = work_ff;
      ctr_in  = ctr_ff;
      step_in = step_ff;
      col_in  = col_ff;
      diag_in = diag_ff;
      dr_in   = dr_ff;
      word_in = word_ff;
      case (state_ff)
         CS_IDLE: begin
            if (cmd_in.start) begin
               work_in = init_w;
               ctr_in  = cmd_in.count;
               step_in = 2'd0;
               col_in  = 2'd0;
               diag_in = 1'b0;
               dr_in   = '0;
            end
         end
         CS_ROUND: begin
            work_in = qr_end ? row_rot : stepped;
            step_in = step_ff + 2'd1;
            if (qr_end) begin
               col_in = col_ff + 2'd1;
            end
            if (half_end) begin
               diag_in = !diag_ff;
            end
         end
         CS_DIAG: begin
            work_in = diag_w;
         end
         CS_UNDIAG: begin
            work_in = undiag_w;
            dr_in   = dr_ff + 1'b1;
            word_in = 4'd0;
         end
         CS_ADD: begin
            for (int i = 0; i < 15; i++) begin
               work_in[i] = work_ff[i + 1];
            end
            work_in[15] = sum;
            word_in     = word_ff + 4'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         step_ff  <= 2'd0;
         col_ff   <= 2'd0;
         diag_ff  <= 1'b0;
         dr_ff    <= '0;
         word_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         col_ff   <= col_in;
         diag_ff  <= diag_in;
         dr_ff    <= dr_in;
         word_ff  <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      ctr_ff  <= ctr_in;
   end

endmodule

>>> rtl/chacha20_stream_cipher_top.sv
// ChaCha20 byte stream cipher: request and response channels, registers and byte sequencing.
// A byte that is not the first of a 64-byte block needs no block function run for its response.
// The first byte of a block waits for the block function to finish.
// That wait comes from the single add-xor-rotate unit doing one quarter-round step a cycle.
// One request is in flight at a time: a byte is taken only once the last response is loaded.
// Synchronous reset clears the registers, the block counter and the message state.
module chacha20_stream_cipher_top #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DR_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cc20_pkg::cc20_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cc20_pkg::cc20_rsp_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cc20_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_data
);
   import cc20_pkg::*;

   cc20_top_state_type state_ff, state_in;
   cc20_block_cfg_type cfg_ff, cfg_in;
   logic [31:0]        init_ctr_ff, init_ctr_in;
   logic [31:0]        block_count_ff, block_count_in;
   logic [5:0]         byte_pos_ff, byte_pos_in;
   logic               in_msg_ff, in_msg_in;
   logic [5:0]         pos_ff;
   cc20_req_type       data_ff;
   cc20_rsp_type       rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept, rsp_load, block_start;
   logic [5:0]         start_pos;
   logic [31:0]        start_cnt;
   cc20_cmd_type       cmd;
   cc20_status_type    status;
   logic [7:0]         ks_byte;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign accept      = req_valid && req_ready;
   assign start_pos   = in_msg_ff ? byte_pos_ff : 6'd0;
   assign start_cnt   = in_msg_ff ? block_count_ff : init_ctr_ff;
   assign block_start = (start_pos == 6'd0);

   cc20_core #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cmd_in      (cmd),
      .cfg_in      (cfg_ff),
      .pos_in      (pos_ff),
      .status_out  (status),
      .ks_byte_out (ks_byte)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TS_IDLE: begin
            if (accept) begin
               state_in = block_start ? TS_GEN : TS_OUT;
            end
         end
         TS_GEN: begin
            if (status.done) begin
               state_in = TS_OUT;
            end
         end
         TS_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = TS_IDLE;
            end
         end
         default: state_in = TS_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == TS_IDLE);
      rsp_load  = (state_ff == TS_OUT) && (!rsp_valid_ff || rsp_ready);
      cmd.start = accept && block_start;
      cmd.count = start_cnt;
   end

   always_comb begin
      cfg_in      = cfg_ff;
      init_ctr_in = init_ctr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_01:   cfg_in.key[1:0]   = csr_data;
            CSR_KEY_23:   cfg_in.key[3:2]   = csr_data;
            CSR_KEY_45:   cfg_in.key[5:4]   = csr_data;
            CSR_KEY_67:   cfg_in.key[7:6]   = csr_data;
            CSR_NONCE_01: cfg_in.nonce[1:0] = csr_data;
            CSR_NONCE_2:  cfg_in.nonce[2]   = csr_data[31:0];
            CSR_INIT_CTR: init_ctr_in       = csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      block_count_in = block_count_ff;
      byte_pos_in    = byte_pos_ff;
      in_msg_in      = in_msg_ff;
      if (accept) begin
         block_count_in = block_start ? start_cnt + 32'd1 : start_cnt;
         byte_pos_in    = start_pos + 6'd1;
         in_msg_in      = !req_data.last_byte;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= TS_IDLE;
         cfg_ff         <= '0;
         init_ctr_ff    <= 32'd0;
         block_count_ff <= 32'd0;
         byte_pos_ff    <= 6'd0;
         in_msg_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cfg_ff         <= cfg_in;
         init_ctr_ff    <= init_ctr_in;
         block_count_ff <= block_count_in;
         byte_pos_ff    <= byte_pos_in;
         in_msg_ff      <= in_msg_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
         pos_ff  <= start_pos;
      end
      if (rsp_load) begin
         rsp_ff.out_byte <= data_ff.data_byte ^ ks_byte;
         rsp_ff.out_last <= data_ff.last_byte;
      end
   end

endmodule

>>> rtl/cc20_checker.sv
// Port-level checks on the ChaCha20 stream cipher, bound to its top level.
module cc20_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cc20_pkg::cc20_rsp_type rsp_data
);

   // A single request is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another was in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed or vanished");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // A new response is only produced while no request can be taken.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a request in progress");

endmodule

bind chacha20_stream_cipher_top cc20_checker u_cc20_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> bench/testbench.sv
// Self-checking testbench for the ChaCha20 byte stream cipher, with its own keystream predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cc20_pkg::*;

   localparam int N_DR = 10;
   localparam int RESET_CYCLES = 12;
   localparam int N_ITEMS = 1650;
   localparam int CALM_AT = 1400;
   localparam int WATCHDOG = 4000;
   localparam int N_DIR = 19;

   localparam logic [3:0][31:0] EXPAND_WORDS = {32'h6b206574, 32'h79622d32,
                                                32'h3320646e, 32'h61707865};

   localparam logic [CSR_INDEX_W-1:0] CSR_ORDER [7] = '{CSR_KEY_01, CSR_KEY_23,
      CSR_KEY_45, CSR_KEY_67, CSR_NONCE_01, CSR_NONCE_2, CSR_INIT_CTR};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [7:0] want;
   } stim_row_type;

   // The typed rows follow the keystream of an all-zero key, nonce and counter.
   localparam stim_row_type DIRECTED [N_DIR] = '{
      '{8'h00, 1'b0, 1'b1, 8'h76}, '{8'h00, 1'b0, 1'b1, 8'hb8},
      '{8'h00, 1'b0, 1'b1, 8'he0}, '{8'h00, 1'b0, 1'b1, 8'had},
      '{8'hff, 1'b0, 1'b1, 8'h5f}, '{8'hff, 1'b0, 1'b1, 8'h0e},
      '{8'hff, 1'b0, 1'b1, 8'hc2}, '{8'hff, 1'b0, 1'b1, 8'h6f},
      '{8'hff, 1'b1, 1'b1, 8'hbf}, '{8'h00, 1'b0, 1'b1, 8'h76},
      '{8'h00, 1'b1, 1'b1, 8'hb8}, '{8'h55, 1'b1, 1'b1, 8'h23},
      '{8'h00, 1'b1, 1'b1, 8'h76}, '{8'h80, 1'b0, 1'b0, 8'h00},
      '{8'h7f, 1'b0, 1'b0, 8'h00}, '{8'h01, 1'b0, 1'b0, 8'h00},
      '{8'hfe, 1'b0, 1'b0, 8'h00}, '{8'haa, 1'b0, 1'b0, 8'h00},
      '{8'h55, 1'b1, 1'b0, 8'h00}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   cc20_req_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   cc20_rsp_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   logic [63:0]      key_cfg [4] = '{default: '0};
   logic [63:0]      nonce01 = '0;
   logic [31:0]      nonce2 = '0;
   logic [31:0]      ctr_init = '0;
   logic [15:0][31:0] ks_words = '0;
   logic [5:0]       pos = '0;
   logic [31:0]      blk_ctr = '0;
   logic             msg_open = 1'b0;

   cc20_rsp_type expected_bytes [$];
   cc20_rsp_type want_rsp;
   int sent = 0;
   int messages = 0;
   int blocks_made = 0;
   int checked = 0;
   int fail_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int quiet = 0;

   chacha20_stream_cipher_top #(
      .DOUBLE_ROUNDS(N_DR)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [15:0][31:0] qround(input logic [15:0][31:0] w,
                                                input int a, input int b,
                                                input int c, input int d);
      w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
      w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
      w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
      w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
      return w;
   endfunction

   function automatic logic [15:0][31:0] keystream_block(input logic [31:0] ctr);
      logic [15:0][31:0] st;
      logic [15:0][31:0] w;
      for (int i = 0; i < 4; i++) begin
         st[i] = EXPAND_WORDS[i];
         st[4 + 2 * i] = key_cfg[i][31:0];
         st[5 + 2 * i] = key_cfg[i][63:32];
      end
      st[12] = ctr;
      st[13] = nonce01[31:0];
      st[14] = nonce01[63:32];
      st[15] = nonce2;
      w = st;
      for (int r = 0; r < N_DR; r++) begin
         w = qround(w, 0, 4, 8, 12);
         w = qround(w, 1, 5, 9, 13);
         w = qround(w, 2, 6, 10, 14);
         w = qround(w, 3, 7, 11, 15);
         w = qround(w, 0, 5, 10, 15);
         w = qround(w, 1, 6, 11, 12);
         w = qround(w, 2, 7, 8, 13);
         w = qround(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
         w[i] = w[i] + st[i];
      end
      return w;
   endfunction

   function automatic cc20_rsp_type cipher_byte(input cc20_req_type r);
      cc20_rsp_type o;
      logic [31:0] kw;
      if (!msg_open) begin
         blk_ctr = ctr_init;
         pos = '0;
      end
      if (pos == 6'd0) begin
         ks_words = keystream_block(blk_ctr);
         blk_ctr = blk_ctr + 32'd1;
         blocks_made++;
      end
      kw = ks_words[pos[5:2]];
      o.out_byte = r.data_byte ^ kw[8 * pos[1:0] +: 8];
      o.out_last = r.last_byte;
      pos = pos + 6'd1;
      msg_open = !r.last_byte;
      return o;
   endfunction

   task automatic send_request(input cc20_req_type r, input logic typed,
                               input logic [7:0] typed_byte);
      cc20_rsp_type predicted;
      if (sent >= CALM_AT) begin
         gap_pct = 0;
         stall_pct = 0;
      end
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = cipher_byte(r);
      if (typed) begin
         predicted.out_byte = typed_byte;
      end
      expected_bytes.push_back(predicted);
      sent++;
      if (r.last_byte) begin
         messages++;
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY_01: key_cfg[0] = val;
         CSR_KEY_23: key_cfg[1] = val;
         CSR_KEY_45: key_cfg[2] = val;
         CSR_KEY_67: key_cfg[3] = val;
         CSR_NONCE_01: nonce01 = val;
         CSR_NONCE_2: nonce2 = val[31:0];
         CSR_INIT_CTR: ctr_init = val[31:0];
         default: ;
      endcase
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= (stall_left == 0);
         end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 6);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         checked++;
         if (expected_bytes.size() == 0) begin
            $error("response %02h/%0b arrived with no request outstanding",
                   rsp_data.out_byte, rsp_data.out_last);
            fail_count++;
         end else begin
            want_rsp = expected_bytes.pop_front();
            if (rsp_data.out_byte !== want_rsp.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want_rsp.out_byte, rsp_data.out_byte);
               fail_count++;
            end
            if (rsp_data.out_last !== want_rsp.out_last) begin
               $error("out_last: expected %0b, got %0b", want_rsp.out_last, rsp_data.out_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG) begin
         $display("Watchdog: no handshake for %0d cycles", quiet);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int phase;
      int n_msgs;
      int len;
      logic leave_open;
      logic [63:0] v;
      cc20_req_type r;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 20;
      stall_pct = 20;
      for (int i = 0; i < N_DIR; i++) begin
         send_request({DIRECTED[i].data, DIRECTED[i].last}, DIRECTED[i].typed, DIRECTED[i].want);
      end

      phase = 0;
      while (sent < N_ITEMS) begin
         req_valid <= 1'b0;
         while (expected_bytes.size() != 0) @(posedge clock);
         // The first two settings are the extremes and the counter is placed just below its wrap.
         for (int i = 0; i < 7; i++) begin
            if (phase < 2 || $urandom_range(0, 1) == 1) begin
               if (phase == 0) begin
                  v = '1;
               end else if (phase == 1) begin
                  v = '0;
               end else begin
                  v = {$urandom, $urandom};
               end
               if (CSR_ORDER[i] == CSR_INIT_CTR) begin
                  if (phase == 1) begin
                     v = 64'h0000_0000_ffff_fffe;
                  end else if (phase > 1 && $urandom_range(0, 2) == 0) begin
                     v[31:0] = 32'hffff_ffff - $urandom_range(0, 2);
                  end
               end
               write_csr(CSR_ORDER[i], v);
            end
         end
         csr_valid <= 1'b0;
         gap_pct = 20 * $urandom_range(0, 3);
         stall_pct = 20 * $urandom_range(0, 3);
         n_msgs = $urandom_range(1, 5);
         leave_open = ($urandom_range(0, 3) == 0);
         for (int m = 0; m < n_msgs; m++) begin
            if (phase < 2 && m == 0) begin
               len = 130;
            end else if ($urandom_range(0, 4) == 0) begin
               len = $urandom_range(65, 150);
            end else begin
               len = $urandom_range(1, 40);
            end
            if (len > N_ITEMS - sent) begin
               len = N_ITEMS - sent;
            end
            for (int b = 0; b < len; b++) begin
               r.data_byte = 8'($urandom);
               r.last_byte = (b == len - 1) && !(leave_open && m == n_msgs - 1);
               send_request(r, 1'b0, 8'h00);
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d requests in %0d complete messages under %0d register settings.",
               sent, messages, phase + 1);
      $display("Predicted %0d keystream blocks and checked %0d responses.",
               blocks_made, checked);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/cc20_pkg.sv
rtl/cc20_core.sv
rtl/chacha20_stream_cipher_top.sv
rtl/cc20_checker.sv
bench/testbench.sv
